### sv/epfm_pkg.sv
package epfm_pkg;

    // field widths fixed by the interface
    localparam int EDGE_TIME_W = 32;
    localparam int FREQ_W      = 28;
    localparam int RES_W       = 27;
    localparam int MINUS_W     = 16;
    localparam int MAXF_W      = 20;
    localparam int TMO_W       = 16;
    localparam int MS_W        = 17;

    // item kinds
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // register indexes
    localparam logic [1:0] REG_RES     = 2'd0;
    localparam logic [1:0] REG_MIN_US  = 2'd1;
    localparam logic [1:0] REG_MAX_HZ  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // register reset values
    localparam logic [RES_W-1:0]   RES_RST     = 27'd80000000;
    localparam logic [MINUS_W-1:0] MIN_US_RST  = 16'd100;
    localparam logic [MAXF_W-1:0]  MAX_HZ_RST  = 20'd20000;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd500;

    localparam logic [MS_W-1:0] MS_MAX = 17'h1FFFF;

    // ticks-per-microsecond divider: quotient of a 27-bit value by 1e6 fits 8 bits
    localparam int            US_PER_S    = 1000000;
    localparam int            MQ_W        = 8;
    localparam logic [27:0]   MDIV_TOP    = 28'(US_PER_S * (2 ** (MQ_W - 1)));
    localparam int            MIN_TICKS_W = MQ_W + MINUS_W;

    typedef struct packed {
        logic                   cmd;
        logic [EDGE_TIME_W-1:0] edge_time;
        logic                   edge_rising;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_q8;
        logic              updated;
        logic              glitch_rejected;
        logic              signal_lost;
    } t_out_item;

endpackage

### sv/edge_period_frequency_meter.sv
// Edge period / frequency meter.
// Input channel (i_in_valid / o_in_stall, i_in_item): each item is either a
// capture edge (timestamp + polarity) or a one-millisecond tick. Every item
// gives exactly one result item on the output channel (o_out_valid /
// i_out_stall, o_out_item): current frequency in Q.FRAC_BITS, plus flags.
// Ticks and edges that do not close a rise-fall-rise window give their result
// in the cycle after acceptance. An edge that closes the window runs a serial
// sequence: a shift-subtract division of the timer rate by 1e6, a multiply for
// the minimum pulse, a compare step, then a restoring divider (one quotient
// bit per cycle) and a final check. The sequence stops after the compare step
// when a glitch is found or the period or rate is zero. One item is in work
// at a time; the next item is taken as soon as the sequence is done and the
// output register is free or being emptied.
// While the receiver stalls, the result holds and further items are stalled.
// Synchronous reset clears the edge window, frequency, ms counter and output,
// and loads the register defaults (80 MHz, 100 us, 20 kHz, 500 ms).
// Configuration is written over the APB port at byte address 4*index.
module edge_period_frequency_meter #(
    parameter int TIME_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  epfm_pkg::t_in_item  i_in_item,
    // result item channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output epfm_pkg::t_out_item o_out_item,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import epfm_pkg::*;

    // dividend is rate << FRAC_BITS
    localparam int DW    = RES_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW);
    localparam int CMP_W = (TIME_BITS > MIN_TICKS_W) ? TIME_BITS : MIN_TICKS_W;
    localparam logic [DW-1:0] FRAC_MASK = DW'((64'(1) << FRAC_BITS) - 64'(1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MDIV,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [RES_W-1:0]   r_res;
    logic [MINUS_W-1:0] r_min_us;
    logic [MAXF_W-1:0]  r_max_hz;
    logic [TMO_W-1:0]   r_timeout;

    // edge window and measurement state
    logic [TIME_BITS-1:0] r_older_time;
    logic                 r_older_rising;
    logic [TIME_BITS-1:0] r_newer_time;
    logic                 r_newer_rising;
    logic [1:0]           r_fill;
    logic [FREQ_W-1:0]    r_freq;
    logic [MS_W-1:0]      r_ms;

    // sequencer datapath
    logic [TIME_BITS-1:0]   r_high;
    logic [TIME_BITS-1:0]   r_low;
    logic [TIME_BITS-1:0]   r_period;
    logic [RES_W-1:0]       r_mrem;
    logic [27:0]            r_dsub;
    logic [MQ_W-1:0]        r_mquo;
    logic [MIN_TICKS_W-1:0] r_min_ticks;
    logic [TIME_BITS-1:0]   r_rem;
    logic [DW-1:0]          r_quo;
    logic [CNT_W-1:0]       r_cnt;

    logic      r_out_valid;
    t_out_item r_out;

    logic                 in_acc;
    logic                 cfg_wr;
    logic [TIME_BITS-1:0] now;
    logic                 pattern;
    logic [MS_W-1:0]      n_ms;
    logic                 n_lost;
    logic                 m_ge;
    logic [TIME_BITS:0]   n_trial;
    logic                 n_qbit;
    logic [TIME_BITS-1:0] n_rem;
    logic                 glitch;
    logic                 early_end;
    logic [DW-1:0]        q_int;
    logic                 rate_ok;
    logic                 out_load;

    assign o_in_stall  = (r_state != S_IDLE) | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_RES:     prdata = 32'(r_res);
            REG_MIN_US:  prdata = 32'(r_min_us);
            REG_MAX_HZ:  prdata = 32'(r_max_hz);
            REG_TIMEOUT: prdata = 32'(r_timeout);
            default:     prdata = '0;
        endcase
    end

    // edge timestamp at the internal timer width
    assign now     = TIME_BITS'(i_in_item.edge_time);
    assign pattern = (r_fill == 2'd2) & r_older_rising & ~r_newer_rising
                   & i_in_item.edge_rising;

    // tick: saturating ms count, timeout test after the increment
    assign n_ms   = (r_ms < MS_MAX) ? r_ms + 1'b1 : r_ms;
    assign n_lost = n_ms > MS_W'(r_timeout);

    // one step of rate / 1e6
    assign m_ge = {1'b0, r_mrem} >= r_dsub;

    // one step of the restoring divider
    assign n_trial = {r_rem, r_quo[DW-1]};
    assign n_qbit  = n_trial >= {1'b0, r_period};
    assign n_rem   = n_qbit ? TIME_BITS'(n_trial - {1'b0, r_period})
                            : TIME_BITS'(n_trial);

    assign glitch = (CMP_W'(r_high) < CMP_W'(r_min_ticks))
                  | (CMP_W'(r_low) < CMP_W'(r_min_ticks));

    // glitch, zero period or zero rate: no division needed
    assign early_end = glitch | (r_period == '0) | (r_res == '0);

    // rate <= max * period, from the integer quotient and the remainder
    assign q_int   = r_quo >> FRAC_BITS;
    assign rate_ok = (q_int < DW'(r_max_hz))
                   | ((q_int == DW'(r_max_hz)) & ((r_quo & FRAC_MASK) == '0)
                      & (r_rem == '0));

    // a result item is loaded into the output register this cycle
    assign out_load = ((r_state == S_IDLE) & in_acc
                       & ((i_in_item.cmd == CMD_TICK) | ~pattern))
                    | ((r_state == S_CHECK) & early_end)
                    | (r_state == S_FIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_res          <= RES_RST;
            r_min_us       <= MIN_US_RST;
            r_max_hz       <= MAX_HZ_RST;
            r_timeout      <= TIMEOUT_RST;
            r_older_time   <= '0;
            r_older_rising <= 1'b0;
            r_newer_time   <= '0;
            r_newer_rising <= 1'b0;
            r_fill         <= '0;
            r_freq         <= '0;
            r_ms           <= '0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_RES:     r_res     <= pwdata[RES_W-1:0];
                    REG_MIN_US:  r_min_us  <= pwdata[MINUS_W-1:0];
                    REG_MAX_HZ:  r_max_hz  <= pwdata[MAXF_W-1:0];
                    REG_TIMEOUT: r_timeout <= pwdata[TMO_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_item.cmd == CMD_TICK) begin
                            r_ms <= n_ms;
                            if (n_lost) begin
                                r_freq <= '0;
                            end
                            r_out.freq_q8         <= n_lost ? '0 : r_freq;
                            r_out.updated         <= 1'b0;
                            r_out.glitch_rejected <= 1'b0;
                            r_out.signal_lost     <= n_lost;
                        end else begin
                            r_ms           <= '0;
                            r_older_time   <= r_newer_time;
                            r_older_rising <= r_newer_rising;
                            r_newer_time   <= now;
                            r_newer_rising <= i_in_item.edge_rising;
                            if (r_fill != 2'd2) begin
                                r_fill <= r_fill + 1'b1;
                            end
                            r_high   <= r_newer_time - r_older_time;
                            r_low    <= now - r_newer_time;
                            r_period <= now - r_older_time;
                            if (pattern) begin
                                r_mrem  <= r_res;
                                r_dsub  <= MDIV_TOP;
                                r_mquo  <= '0;
                                r_cnt   <= CNT_W'(MQ_W - 1);
                                r_state <= S_MDIV;
                            end else begin
                                r_out.freq_q8         <= r_freq;
                                r_out.updated         <= 1'b0;
                                r_out.glitch_rejected <= 1'b0;
                                r_out.signal_lost     <= 1'b0;
                            end
                        end
                    end
                end
                S_MDIV: begin
                    if (m_ge) begin
                        r_mrem <= RES_W'({1'b0, r_mrem} - r_dsub);
                    end
                    r_mquo <= {r_mquo[MQ_W-2:0], m_ge};
                    r_dsub <= r_dsub >> 1;
                    if (r_cnt == '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MUL: begin
                    r_min_ticks <= MIN_TICKS_W'(r_mquo) * MIN_TICKS_W'(r_min_us);
                    r_state     <= S_CHECK;
                end
                S_CHECK: begin
                    if (early_end) begin
                        r_out.freq_q8         <= r_freq;
                        r_out.updated         <= 1'b0;
                        r_out.glitch_rejected <= glitch;
                        r_out.signal_lost     <= 1'b0;
                        r_state               <= S_IDLE;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= DW'(r_res) << FRAC_BITS;
                        r_cnt   <= CNT_W'(DW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[DW-2:0], n_qbit};
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIN: begin
                    if (rate_ok) begin
                        r_freq <= FREQ_W'(r_quo);
                    end
                    r_out.freq_q8         <= rate_ok ? FREQ_W'(r_quo) : r_freq;
                    r_out.updated         <= rate_ok;
                    r_out.glitch_rejected <= 1'b0;
                    r_out.signal_lost     <= 1'b0;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/edge_period_frequency_meter_tb.sv
`timescale 1ns / 100ps

module edge_period_frequency_meter_tb;
    import epfm_pkg::*;

    // fraction bits of the Q format, matches the DUT default
    localparam int FRAC          = 8;
    // quiet cycles after the last reading before a register write or the end
    localparam int SETTLE_CYCLES = 60;
    // cycles with no item moved on either side and no config access before the run is abandoned
    localparam int WD_LIMIT      = 4000;

    // idle modes of a phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    // ---------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    edge_period_frequency_meter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Meter model: window, frequency, ms counter and register copies
    // ---------------------------------------------------------------
    logic [RES_W-1:0]   res_cfg   = RES_RST;
    logic [MINUS_W-1:0] minus_cfg = MIN_US_RST;
    logic [MAXF_W-1:0]  maxhz_cfg = MAX_HZ_RST;
    logic [TMO_W-1:0]   tmo_cfg   = TIMEOUT_RST;

    logic [31:0]       win_old_t    = '0;
    logic              win_old_rise = 1'b0;
    logic [31:0]       win_new_t    = '0;
    logic              win_new_rise = 1'b0;
    int                win_fill     = 0;
    logic [FREQ_W-1:0] freq_acc     = '0;
    logic [MS_W-1:0]   ms_cnt       = '0;

    t_in_item  item_feed_q[$];   // items still to be offered
    t_out_item reading_q[$];     // predicted readings, oldest first

    int idle_mode    = IDLE_NONE;
    int bad_fields   = 0;
    int items_taken  = 0;
    int readings_ok  = 0;
    int upd_cnt      = 0;
    int glitch_cnt   = 0;
    int lost_cnt     = 0;
    int phases_run   = 0;
    int quiet_cycles = 0;

    // One item through the meter: updates the model state, returns the reading.
    function automatic t_out_item meter_step(input t_in_item it);
        t_out_item   r;
        logic [63:0] min_ticks, hi, lo, per, res64;
        logic [31:0] d_hi, d_lo, d_per;
        logic        upd, glt, ok;
        upd = 1'b0;
        glt = 1'b0;
        if (it.cmd == CMD_TICK) begin
            // ms counter saturates; timeout checked after the increment
            if (ms_cnt < MS_MAX) ms_cnt = ms_cnt + 1'b1;
            if (ms_cnt > tmo_cfg) freq_acc = '0;
        end else begin
            ms_cnt = '0;
            if (win_fill < 2) begin
                // window filling, no pattern yet
                win_fill = win_fill + 1;
            end else if (win_old_rise && !win_new_rise && it.edge_rising) begin
                min_ticks = (64'(res_cfg) / 64'(US_PER_S)) * 64'(minus_cfg);
                d_hi  = win_new_t - win_old_t;
                d_lo  = it.edge_time - win_new_t;
                d_per = it.edge_time - win_old_t;
                hi    = 64'(d_hi);
                lo    = 64'(d_lo);
                per   = 64'(d_per);
                res64 = 64'(res_cfg);
                if (hi < min_ticks || lo < min_ticks) begin
                    glt = 1'b1;
                end else if (per != 0 && res64 != 0) begin
                    // exact frequency limit: res / per <= max  <=>  res <= max * per
                    if (per > res64) ok = (maxhz_cfg >= 1);
                    else ok = (res64 <= 64'(maxhz_cfg) * per);
                    if (ok) begin
                        freq_acc = FREQ_W'((res64 << FRAC) / per);
                        upd = 1'b1;
                    end
                end
            end
            win_old_t    = win_new_t;
            win_old_rise = win_new_rise;
            win_new_t    = it.edge_time;
            win_new_rise = it.edge_rising;
        end
        r.freq_q8         = freq_acc;
        r.updated         = upd;
        r.glitch_rejected = glt;
        r.signal_lost     = (ms_cnt > tmo_cfg);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Idling: per-cycle random gaps at the phase's rate
    // ---------------------------------------------------------------
    function automatic bit roll_idle(input bit sender);
        int pct;
        if (idle_mode == IDLE_BOTH) pct = 18;
        else if (sender && idle_mode == IDLE_SEND) pct = 81;
        else if (!sender && idle_mode == IDLE_RECV) pct = 81;
        else pct = 0;
        return ($urandom_range(0, 99) < pct);
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued items; a stalled item holds its payload
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_stall === 1'b0) begin
            // slot empty or the current item is taken at this edge
            if (item_feed_q.size() != 0 && !roll_idle(1'b1)) begin
                i_in_item  <= item_feed_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= roll_idle(1'b0);
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_in_valid && o_in_stall === 1'b0) begin
            reading_q.push_back(meter_step(i_in_item));
            items_taken++;
        end
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            if (reading_q.size() == 0) begin
                $error("result item with no reading pending");
                bad_fields++;
            end else begin
                want = reading_q.pop_front();
                readings_ok++;
                if (want.updated) upd_cnt++;
                if (want.glitch_rejected) glitch_cnt++;
                if (want.signal_lost) lost_cnt++;
                if (o_out_item.freq_q8 !== want.freq_q8) begin
                    $error("freq_q8: expected %0d, got %0d", want.freq_q8, o_out_item.freq_q8);
                    bad_fields++;
                end
                if (o_out_item.updated !== want.updated) begin
                    $error("updated: expected %0b, got %0b", want.updated, o_out_item.updated);
                    bad_fields++;
                end
                if (o_out_item.glitch_rejected !== want.glitch_rejected) begin
                    $error("glitch_rejected: expected %0b, got %0b",
                           want.glitch_rejected, o_out_item.glitch_rejected);
                    bad_fields++;
                end
                if (o_out_item.signal_lost !== want.signal_lost) begin
                    $error("signal_lost: expected %0b, got %0b",
                           want.signal_lost, o_out_item.signal_lost);
                    bad_fields++;
                end
            end
        end
    end

    // Watchdog: nothing moved on either channel or the config port for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void push_edge(input logic [31:0] at, input logic rise);
        t_in_item x;
        x.cmd         = CMD_EDGE;
        x.edge_time   = at;
        x.edge_rising = rise;
        item_feed_q.push_back(x);
    endfunction

    // tick with junk in the ignored fields
    function automatic void push_tick();
        t_in_item x;
        x.cmd         = CMD_TICK;
        x.edge_time   = $urandom;
        x.edge_rising = 1'($urandom_range(0, 1));
        item_feed_q.push_back(x);
    endfunction

    // phase length around the interesting points: min pulse, rate limit
    function automatic logic [31:0] pick_span(input logic [31:0] mt, input logic [31:0] lim);
        case ($urandom_range(0, 5))
            0: return mt - 1;
            1: return mt;
            2: return mt + $urandom_range(0, 1000);
            3: return (lim >> 1) + $urandom_range(0, lim);
            4: return $urandom;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // APB write: setup then access, done once pready is seen with penable
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RES:     res_cfg   = val[RES_W-1:0];
            REG_MIN_US:  minus_cfg = val[MINUS_W-1:0];
            REG_MAX_HZ:  maxhz_cfg = val[MAXF_W-1:0];
            REG_TIMEOUT: tmo_cfg   = val[TMO_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every item went in and every reading came out, then settle
    task automatic drain();
        while (item_feed_q.size() != 0 || i_in_valid || reading_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random stream: mostly alternating fall/rise edges with phases aimed at
    // the limits, plus ticks, timeout bursts and stray edges.
    task automatic gen_random(input int n_items);
        logic [31:0] mt, lim, hi, lo, t;
        logic        last_rise, pol;
        int          sel, burst;
        mt = (res_cfg / US_PER_S) * minus_cfg;
        if (res_cfg == 0 || maxhz_cfg == 0) lim = 32'd1000;
        else lim = (32'(res_cfg) + 32'(maxhz_cfg) - 1) / 32'(maxhz_cfg);
        t = $urandom;
        last_rise = 1'b1;
        while (item_feed_q.size() < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                if (last_rise) begin
                    hi = pick_span(mt, lim);
                    // a quarter of patterns sit on the rate limit or one below
                    if ($urandom_range(0, 3) == 0) lo = lim - hi - $urandom_range(0, 1);
                    else lo = pick_span(mt, lim);
                    t = t + hi;
                    push_edge(t, 1'b0);
                    t = t + lo;
                    push_edge(t, 1'b1);
                end else begin
                    t = t + pick_span(mt, lim);
                    push_edge(t, 1'b1);
                end
                last_rise = 1'b1;
            end else if (sel < 70) begin
                push_tick();
            end else if (sel < 75) begin
                // with a short timeout run up to it and just past it, else one to four ticks
                if (tmo_cfg <= 40) burst = int'(tmo_cfg) + $urandom_range(0, 3);
                else burst = $urandom_range(1, 4);
                repeat (burst) push_tick();
            end else begin
                pol = 1'($urandom_range(0, 1));
                if (sel < 88) t = t + $urandom_range(0, 2 * mt + 3);
                else t = $urandom;
                push_edge(t, pol);
                last_rise = pol;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] res_v, input logic [31:0] minus_v,
                             input logic [31:0] maxhz_v, input logic [31:0] tmo_v,
                             input int mode, input int n_items);
        apb_write(REG_RES, res_v);
        apb_write(REG_MIN_US, minus_v);
        apb_write(REG_MAX_HZ, maxhz_v);
        apb_write(REG_TIMEOUT, tmo_v);
        @(negedge i_clk);
        idle_mode = mode;
        gen_random(n_items);
        drain();
        phases_run++;
    endtask

    // ---------------------------------------------------------------
    // Sequence: reset, directed items at reset defaults, random phases
    // ---------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Defaults: 80 MHz, 100 us -> 8000 ticks minimum phase, 20 kHz limit.
        push_tick();                        // tick before any edge
        push_edge(32'h0000_1000, 1'b1);     // the opening edges only fill the window
        push_edge(32'h0000_3710, 1'b0);
        push_edge(32'h0000_5E20, 1'b1);     // clean 10000/10000 pattern
        push_edge(32'h0000_7D5F, 1'b0);     // high phase one tick short
        push_edge(32'h0000_A46F, 1'b1);
        push_edge(32'h0000_C3AF, 1'b0);     // both phases exactly at minimum
        push_edge(32'h0000_E2EF, 1'b1);
        push_tick();
        push_edge(32'hFFFF_E000, 1'b1);     // rise after rise: no pattern
        push_edge(32'h0000_1000, 1'b0);     // timer wraps inside the pattern
        push_edge(32'h0000_4000, 1'b1);
        push_edge(32'h8000_4000, 1'b0);     // period wraps to zero
        push_edge(32'h0000_4000, 1'b1);
        push_edge(32'hFFFF_FFFF, 1'b0);     // all-ones timestamp, short low
        push_edge(32'h0000_0000, 1'b1);
        push_edge(32'h4000_0000, 1'b0);     // period longer than the rate
        push_edge(32'h8000_0000, 1'b1);
        push_tick();
        drain();
        phases_run++;

        // extremes first, then random settings; idle mode rotates
        run_phase(32'd1000000, 32'd0, 32'd1000000, 32'd1, IDLE_SEND, 145);
        run_phase(32'd100000000, 32'd65535, 32'd1, 32'd65535, IDLE_RECV, 145);
        run_phase(32'd1, 32'd1, 32'd1000000, 32'd3, IDLE_BOTH, 145);
        // zero rate and zero timeout
        run_phase(32'd0, 32'd10, 32'd20000, 32'd0, IDLE_NONE, 145);
        // zero frequency limit
        run_phase(32'd12000000, 32'd5, 32'd0, 32'd10, IDLE_SEND, 145);
        // all ones written: every register at its field maximum
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_RECV, 145);
        run_phase($urandom_range(1, 100000000), $urandom_range(0, 200),
                  $urandom_range(1000, 1000000), $urandom_range(1, 30), IDLE_BOTH, 145);
        run_phase($urandom_range(1, 100000000), $urandom_range(0, 65535),
                  $urandom_range(1, 1000000), $urandom_range(1, 65535), IDLE_NONE, 145);

        $display("covered %0d items in %0d register settings, %0d readings checked",
                 items_taken, phases_run, readings_ok);
        $display("readings with update %0d, glitch %0d, signal lost %0d",
                 upd_cnt, glitch_cnt, lost_cnt);
        if (bad_fields == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
sv/epfm_pkg.sv
sv/edge_period_frequency_meter.sv
tb/edge_period_frequency_meter_tb.sv
